@@ hw/rtl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg - shared definitions for the serial frame receiver
// Holds the phase encoding, the result kind codes and the structs that pass
// between the top level and the step logic.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // Width of the inter-byte gap timer.
    localparam int TIMER_BITS = 16;

    // Width of the timeout register.
    localparam int TIMEOUT_W = 16;

    // Comparison width covering both the timer and the timeout register.
    localparam int CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(20);

    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    // Input mode codes.
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Result kind codes.
    localparam logic [2:0] KIND_PAYLOAD = 3'd0;
    localparam logic [2:0] KIND_GOOD    = 3'd1;
    localparam logic [2:0] KIND_BADSUM  = 3'd2;
    localparam logic [2:0] KIND_ZEROLEN = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT = 3'd4;

    typedef enum logic [2:0] {
        PH_HUNT0   = 3'd0,
        PH_HUNT1   = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHK     = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t                phase;
        logic [7:0]            frame_length;
        logic [7:0]            byte_count;
        logic [7:0]            running_xor;
        logic [TIMER_BITS-1:0] gap_timer;
    } frame_state_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
        logic [7:0] data;
        logic [7:0] index;
    } result_t;

endpackage

@@ hw/rtl/sfr_step.sv @@
// ----------------------------------------------------------------------------
// sfr_step - deframer state update for one transaction
// Pure combinational logic: from the current frame state and one byte or
// tick it forms the next frame state and at most one result.
// ----------------------------------------------------------------------------
module sfr_step
    import sfr_pkg::*;
(
    input  frame_state_t          state_cur,
    input  logic                  mode,
    input  logic [7:0]            rx_byte,
    input  logic [TIMEOUT_W-1:0]  timeout_ticks,
    output frame_state_t          state_next,
    output result_t               result
);

    logic                  in_frame;
    logic [TIMER_BITS-1:0] timer_inc;
    logic [7:0]            count_inc;

    assign in_frame  = state_cur.phase inside {PH_LEN, PH_PAYLOAD, PH_CHK};
    assign timer_inc = (state_cur.gap_timer == {TIMER_BITS{1'b1}}) ?
                       state_cur.gap_timer : state_cur.gap_timer + 1'b1;
    assign count_inc = state_cur.byte_count + 8'd1;

    always_comb
    begin
        state_next = state_cur;
        result     = '0;

        if (mode == MODE_TICK)
        begin
            if (in_frame)
            begin
                if (CMP_W'(timer_inc) >= CMP_W'(timeout_ticks))
                begin
                    state_next.gap_timer = '0;
                    state_next.phase     = PH_HUNT0;
                    result.valid         = 1'b1;
                    result.kind          = KIND_TIMEOUT;
                end
                else
                begin
                    state_next.gap_timer = timer_inc;
                end
            end
        end
        else
        begin
            state_next.gap_timer = '0;
            case (state_cur.phase)
                PH_HUNT1:
                begin
                    state_next.phase = (rx_byte == SYNC_BYTE) ? PH_LEN : PH_HUNT0;
                end
                PH_LEN:
                begin
                    if (rx_byte == 8'd0)
                    begin
                        state_next.phase = PH_HUNT0;
                        result.valid     = 1'b1;
                        result.kind      = KIND_ZEROLEN;
                    end
                    else
                    begin
                        state_next.frame_length = rx_byte;
                        state_next.byte_count   = 8'd0;
                        state_next.running_xor  = 8'd0;
                        state_next.phase        = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    result.valid           = 1'b1;
                    result.kind            = KIND_PAYLOAD;
                    result.data            = rx_byte;
                    result.index           = state_cur.byte_count;
                    state_next.running_xor = state_cur.running_xor ^ rx_byte;
                    state_next.byte_count  = count_inc;
                    if (count_inc == state_cur.frame_length)
                    begin
                        state_next.phase = PH_CHK;
                    end
                end
                PH_CHK:
                begin
                    state_next.phase = PH_HUNT0;
                    result.valid     = 1'b1;
                    result.kind      = (rx_byte == state_cur.running_xor) ?
                                       KIND_GOOD : KIND_BADSUM;
                    result.data      = rx_byte;
                end
                default:
                begin
                    // First sync byte hunt, and any code outside the encoding.
                    state_next.phase = (rx_byte == SYNC_BYTE) ? PH_HUNT1 : PH_HUNT0;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/serial_frame_receiver_xor.sv @@
// ----------------------------------------------------------------------------
// serial_frame_receiver_xor - sync, length, payload and XOR checksum deframer
// Datapath: an accepted transaction is held in the input register, the step
// logic forms its result, and the result register holds that result on the
// outputs; a result that is still waiting stalls the input register.
// Throughput: one transaction per cycle while no waiting result stalls it,
// set by the combinational state update between the two registers.
// Reset: rst_n is asynchronous and active low; it empties both registers,
// returns to the hunt for the first sync byte and sets the timeout to 20 ticks.
// ----------------------------------------------------------------------------
module serial_frame_receiver_xor
    import sfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Input channel: one received byte or one time tick per transaction.
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 mode,
    input  logic [7:0]           rx_byte,

    // Result channel.
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           kind,
    output logic [7:0]           data,
    output logic [7:0]           index,

    // Timeout register write port.
    input  logic                 cfg_wr_en,
    input  logic [TIMEOUT_W-1:0] cfg_wr_data
);

    // Configuration register holding the allowed gap in ticks.
    logic [TIMEOUT_W-1:0] timeout_reg;

    // Input register stage.
    logic       s1_valid_reg;
    logic       s1_mode_reg;
    logic [7:0] s1_byte_reg;

    // Frame state, updated once per transaction leaving the input stage.
    frame_state_t state_reg;
    frame_state_t state_next;
    result_t      step_result;

    // Result register stage.
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [2:0] kind_reg;
    logic [7:0] data_reg;
    logic [7:0] index_reg;

    logic out_free;
    logic s1_fire;
    logic res_load;

    // The step logic works on the transaction held in the input register.
    sfr_step u_step
    (
        .state_cur     (state_reg),
        .mode          (s1_mode_reg),
        .rx_byte       (s1_byte_reg),
        .timeout_ticks (timeout_reg),
        .state_next    (state_next),
        .result        (step_result)
    );

    // The result register can take a new result when it is empty or is
    // being emptied in this cycle.
    assign out_free = !out_valid_reg || out_ready;

    // A held transaction moves on when it yields no result, or when the
    // result register has room for the one it yields.
    assign s1_fire  = s1_valid_reg && (!step_result.valid || out_free);
    assign res_load = s1_fire && step_result.valid;

    // A new transaction is taken when the input register empties or is empty,
    // so it takes one transaction per cycle unless a waiting result stalls it.
    assign in_ready = !s1_valid_reg || s1_fire;

    always_comb
    begin
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_HUNT0, default: '0};
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_fire)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_mode_reg <= mode;
            s1_byte_reg <= rx_byte;
        end
        if (res_load)
        begin
            kind_reg  <= step_result.kind;
            data_reg  <= step_result.data;
            index_reg <= step_result.index;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign index     = index_reg;

    // Any result other than a payload byte ends the frame.
    a_end_of_frame_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && step_result.kind != KIND_PAYLOAD) |=> (state_reg.phase == PH_HUNT0))
        else $error("frame did not return to sync hunt after a final result");

    // The gap timer only runs inside a frame.
    a_timer_idle_in_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_HUNT0 || state_reg.phase == PH_HUNT1)
            |-> (state_reg.gap_timer == '0))
        else $error("gap timer non-zero while hunting for sync");

    // While payload is being read, the count has not yet reached the length.
    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_PAYLOAD) |-> (state_reg.byte_count != state_reg.frame_length))
        else $error("payload count reached frame length without leaving payload");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !res_load)
        else $error("result register overwritten while stalled");

endmodule
